// ----- hw/rtl/ste_pkg.sv -----
// Package for the speech turn endpoint detector.
// Holds item codes, event codes, register map, timing constants and the learned-gap helper.
// No dependencies.
package ste_pkg;

  localparam int unsigned FRAME_PERIOD      = 20;
  localparam int unsigned SHORT_SPEECH_SPAN = 600;
  localparam int unsigned LONG_TURN_SPAN    = 3000;
  localparam int unsigned GAP_LEARN_FLOOR   = 300;
  localparam int unsigned TURN_VOICED_FLOOR = 5;

  // voiced_count * FRAME_PERIOD < SHORT_SPEECH_SPAN  <=>  voiced_count < this
  localparam int unsigned SHORT_TURN_FRAMES =
    (SHORT_SPEECH_SPAN + FRAME_PERIOD - 1) / FRAME_PERIOD;

  localparam logic [14:0] IDLE_MIN     = 15'd5000;
  localparam logic [14:0] IDLE_MAX     = 15'd30000;
  localparam logic [17:0] GAP_MARGIN   = 18'd160;
  // floor(g / 3) = (g * DIV3_MUL) >> DIV3_SHIFT for any 16-bit g
  localparam logic [16:0] DIV3_MUL     = 17'd43691;
  localparam int unsigned DIV3_SHIFT   = 17;
  localparam logic [17:0] LEARNED_HUGE = 18'h3FFFF;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned APB_ADDR_W = 5;

  typedef enum logic [1:0] {
    FUNC_FRAME  = 2'd0,
    FUNC_LISTEN = 2'd1,
    FUNC_PRIME  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STARTED  = 3'd1,
    EV_IDLE     = 3'd2,
    EV_NOISE    = 3'd3,
    EV_ENDPOINT = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    REG_IDLE_TIMEOUT  = 3'd0,
    REG_START_FRAMES  = 3'd1,
    REG_NORMAL_SIL    = 3'd2,
    REG_SHORT_SIL     = 3'd3,
    REG_LONG_SIL      = 3'd4,
    REG_SILENCE_CAP   = 3'd5,
    REG_MIN_RECORD    = 3'd6,
    REG_MAX_RECORD    = 3'd7
  } reg_e;

  typedef struct packed {
    logic [14:0] idle_timeout;
    logic [7:0]  start_frames;
    logic [15:0] normal_silence;
    logic [15:0] short_turn_silence;
    logic [15:0] long_turn_silence;
    logic [15:0] silence_cap;
    logic [15:0] min_record;
    logic [15:0] max_record;
  } cfg_t;

  // Learned silence from a gap: 0 below the learning floor, LEARNED_HUGE when the
  // gap is too large for any cap, else gap + gap/3 + margin.
  function automatic logic [17:0] learned_sil(input logic [31:0] gap);
    logic [32:0] prod;
    logic [15:0] third;
    logic [17:0] res;
    prod  = {17'd0, gap[15:0]} * {16'd0, DIV3_MUL};
    third = prod[DIV3_SHIFT +: 16];
    res   = {2'b00, gap[15:0]} + {2'b00, third} + GAP_MARGIN;
    if (gap < 32'(GAP_LEARN_FLOOR)) begin
      res = 18'd0;
    end else if (|gap[31:16]) begin
      res = LEARNED_HUGE;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/speech_turn_endpoint_detector.sv -----
// Speech turn endpoint detector, top level.
// Input register, single-pass turn logic, result register; uses ste_cfg_regs.
// Depends on ste_pkg.

// Takes one request per clock while the output is not stalled and returns one
// event per request, through the input register and then the result register.
// The rate is one request per cycle unless stalled, set by the one-pass update; the
// input side keeps accepting while a result waits, and stalls only when both
// the input register and the result register are full. Request kind on tuser:
// 0 audio frame, 1 start listening, 2 prime speech, 3 ignored. Events: 0 none,
// 1 speech started, 2 idle timeout, 3 short noise, 4 endpoint. Times are ms,
// wrapping modulo 2^32. Write configuration only while no request is in flight.
module speech_turn_endpoint_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: now_time[31:0], voiced[32], guard_time[48:33], prior_frames[64:49], zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ste_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: func[1:0]
  input  logic [ste_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: event_res[2:0], zero pad
  output logic [ste_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ste_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  ste_pkg::cfg_t cfg;

  ste_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  // input register
  logic            in_valid_q;
  ste_pkg::func_e  in_func_q;
  logic [31:0]     in_now_q;
  logic            in_voiced_q;
  logic [15:0]     in_guard_q;
  logic [15:0]     in_prior_q;

  // result register
  logic            out_valid_q;
  ste_pkg::event_e out_event_q, ev;

  logic out_adv, fire, in_take;
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_adv;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // turn state
  logic [31:0] listen_start_q, listen_start_d;
  logic [31:0] guard_until_q,  guard_until_d;
  logic [31:0] speech_start_q, speech_start_d;
  logic [31:0] last_voice_q,   last_voice_d;
  logic [31:0] longest_gap_q,  longest_gap_d;
  logic [15:0] voiced_count_q, voiced_count_d;
  logic [15:0] run_count_q,    run_count_d;
  logic [31:0] run_start_q,    run_start_d;
  logic        speaking_q,     speaking_d;
  logic        gap_open_q,     gap_open_d;
  logic        skip_gap_q,     skip_gap_d;

  logic [31:0] guard_diff, idle_diff, gap, rec, prior_span;
  logic [15:0] run_inc, voiced_inc;
  logic [17:0] lrn_old, lrn_gap;

  assign guard_diff = in_now_q - guard_until_q;
  assign idle_diff  = in_now_q - listen_start_q;
  assign gap        = in_now_q - last_voice_q;
  assign rec        = in_now_q - speech_start_q;
  assign prior_span = {16'd0, in_prior_q} * 32'(ste_pkg::FRAME_PERIOD);
  assign run_inc    = (run_count_q == 16'hFFFF) ? run_count_q : run_count_q + 16'd1;
  assign voiced_inc = (voiced_count_q == 16'hFFFF) ? voiced_count_q : voiced_count_q + 16'd1;
  assign lrn_old    = ste_pkg::learned_sil(longest_gap_q);
  assign lrn_gap    = ste_pkg::learned_sil(gap);

  logic        gap_learned;
  logic [17:0] lrn, sil18;
  logic [15:0] base_sil, target;
  logic [31:0] elapsed, quiet;
  logic        by_silence, by_limit;

  always_comb begin
    listen_start_d = listen_start_q;
    guard_until_d  = guard_until_q;
    speech_start_d = speech_start_q;
    last_voice_d   = last_voice_q;
    longest_gap_d  = longest_gap_q;
    voiced_count_d = voiced_count_q;
    run_count_d    = run_count_q;
    run_start_d    = run_start_q;
    speaking_d     = speaking_q;
    gap_open_d     = gap_open_q;
    skip_gap_d     = skip_gap_q;
    ev             = ste_pkg::EV_NONE;
    gap_learned    = 1'b0;
    lrn            = lrn_old;
    base_sil       = cfg.normal_silence;
    sil18          = 18'd0;
    target         = 16'd0;
    elapsed        = 32'd0;
    quiet          = 32'd0;
    by_silence     = 1'b0;
    by_limit       = 1'b0;

    case (in_func_q)
      ste_pkg::FUNC_FRAME: begin
        if (!speaking_q) begin
          if (guard_diff[31]) begin
            run_start_d = 32'd0;
            run_count_d = 16'd0;
          end else begin
            if (in_voiced_q) begin
              if (run_count_q == 16'd0) begin
                run_start_d = in_now_q;
              end
              run_count_d = run_inc;
              if (run_inc >= {8'd0, cfg.start_frames}) begin
                speaking_d     = 1'b1;
                speech_start_d = run_start_d;
                last_voice_d   = in_now_q;
                voiced_count_d = run_inc;
                gap_open_d     = 1'b0;
                ev             = ste_pkg::EV_STARTED;
              end
            end else begin
              run_start_d = 32'd0;
              run_count_d = 16'd0;
            end
            if (ev == ste_pkg::EV_NONE && idle_diff >= {17'd0, cfg.idle_timeout}) begin
              ev = ste_pkg::EV_IDLE;
            end
          end
        end else begin
          if (in_voiced_q) begin
            if (skip_gap_q) begin
              skip_gap_d = 1'b0;
            end else if (gap_open_q) begin
              if (gap >= 32'(ste_pkg::GAP_LEARN_FLOOR) && gap > longest_gap_q) begin
                longest_gap_d = gap;
                gap_learned   = 1'b1;
              end
              gap_open_d = 1'b0;
            end
            last_voice_d   = in_now_q;
            voiced_count_d = voiced_inc;
            elapsed        = rec;
            quiet          = 32'd0;
          end else begin
            gap_open_d = 1'b1;
            elapsed    = last_voice_q - speech_start_q;
            quiet      = gap;
          end

          lrn = gap_learned ? lrn_gap : lrn_old;
          if (voiced_count_d < 16'(ste_pkg::SHORT_TURN_FRAMES)) begin
            base_sil = cfg.short_turn_silence;
          end else if (elapsed >= 32'(ste_pkg::LONG_TURN_SPAN)) begin
            base_sil = cfg.long_turn_silence;
          end
          sil18 = (lrn > {2'b00, base_sil}) ? lrn : {2'b00, base_sil};
          target = (sil18 > {2'b00, cfg.silence_cap}) ? cfg.silence_cap : sil18[15:0];

          by_silence = (rec >= {16'd0, cfg.min_record}) && (quiet >= {16'd0, target});
          by_limit   = rec >= {16'd0, cfg.max_record};

          if (by_silence || by_limit) begin
            if (voiced_count_d < 16'(ste_pkg::TURN_VOICED_FLOOR)) begin
              speech_start_d = 32'd0;
              last_voice_d   = listen_start_q;
              longest_gap_d  = 32'd0;
              voiced_count_d = 16'd0;
              speaking_d     = 1'b0;
              gap_open_d     = 1'b0;
              skip_gap_d     = 1'b0;
              run_start_d    = 32'd0;
              run_count_d    = 16'd0;
              ev             = ste_pkg::EV_NOISE;
            end else begin
              ev = ste_pkg::EV_ENDPOINT;
            end
          end
        end
      end
      ste_pkg::FUNC_LISTEN: begin
        listen_start_d = in_now_q;
        guard_until_d  = in_now_q + {16'd0, in_guard_q};
        speech_start_d = 32'd0;
        last_voice_d   = in_now_q;
        longest_gap_d  = 32'd0;
        voiced_count_d = 16'd0;
        speaking_d     = 1'b0;
        gap_open_d     = 1'b0;
        skip_gap_d     = 1'b0;
        run_start_d    = 32'd0;
        run_count_d    = 16'd0;
      end
      ste_pkg::FUNC_PRIME: begin
        speaking_d     = 1'b1;
        speech_start_d = in_now_q - prior_span;
        last_voice_d   = in_now_q;
        voiced_count_d = in_prior_q;
        run_count_d    = in_prior_q;
        longest_gap_d  = 32'd0;
        gap_open_d     = 1'b0;
        skip_gap_d     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q   <= ste_pkg::func_e'(s_axis_tuser[1:0]);
      in_now_q    <= s_axis_tdata[31:0];
      in_voiced_q <= s_axis_tdata[32];
      in_guard_q  <= s_axis_tdata[48:33];
      in_prior_q  <= s_axis_tdata[64:49];
    end
    if (fire) begin
      out_event_q <= ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_start_q <= 32'd0;
      guard_until_q  <= 32'd0;
      speech_start_q <= 32'd0;
      last_voice_q   <= 32'd0;
      longest_gap_q  <= 32'd0;
      voiced_count_q <= 16'd0;
      run_count_q    <= 16'd0;
      run_start_q    <= 32'd0;
      speaking_q     <= 1'b0;
      gap_open_q     <= 1'b0;
      skip_gap_q     <= 1'b0;
    end else if (fire) begin
      listen_start_q <= listen_start_d;
      guard_until_q  <= guard_until_d;
      speech_start_q <= speech_start_d;
      last_voice_q   <= last_voice_d;
      longest_gap_q  <= longest_gap_d;
      voiced_count_q <= voiced_count_d;
      run_count_q    <= run_count_d;
      run_start_q    <= run_start_d;
      speaking_q     <= speaking_d;
      gap_open_q     <= gap_open_d;
      skip_gap_q     <= skip_gap_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_event_q};

endmodule

// ----- hw/rtl/ste_cfg_regs.sv -----
// Configuration register file for the speech turn endpoint detector.
// APB-style write/read port; idle timeout is clamped on write.
// Depends on ste_pkg.
module ste_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [ste_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [31:0]                      pwdata_i,
  output logic [31:0]                      prdata_o,
  output ste_pkg::cfg_t                    cfg_o
);

  ste_pkg::cfg_t cfg_q, cfg_d;
  ste_pkg::reg_e idx;
  logic          wr_en;
  logic [14:0]   idle_clamped;

  assign idx   = ste_pkg::reg_e'(paddr_i[4:2]);
  assign wr_en = psel_i & penable_i & pwrite_i;

  always_comb begin
    idle_clamped = pwdata_i[14:0];
    if (idle_clamped < ste_pkg::IDLE_MIN) begin
      idle_clamped = ste_pkg::IDLE_MIN;
    end else if (idle_clamped > ste_pkg::IDLE_MAX) begin
      idle_clamped = ste_pkg::IDLE_MAX;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        ste_pkg::REG_IDLE_TIMEOUT: cfg_d.idle_timeout       = idle_clamped;
        ste_pkg::REG_START_FRAMES: cfg_d.start_frames       = pwdata_i[7:0];
        ste_pkg::REG_NORMAL_SIL:   cfg_d.normal_silence     = pwdata_i[15:0];
        ste_pkg::REG_SHORT_SIL:    cfg_d.short_turn_silence = pwdata_i[15:0];
        ste_pkg::REG_LONG_SIL:     cfg_d.long_turn_silence  = pwdata_i[15:0];
        ste_pkg::REG_SILENCE_CAP:  cfg_d.silence_cap        = pwdata_i[15:0];
        ste_pkg::REG_MIN_RECORD:   cfg_d.min_record         = pwdata_i[15:0];
        ste_pkg::REG_MAX_RECORD:   cfg_d.max_record         = pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ste_pkg::REG_IDLE_TIMEOUT: prdata_o = {17'd0, cfg_q.idle_timeout};
      ste_pkg::REG_START_FRAMES: prdata_o = {24'd0, cfg_q.start_frames};
      ste_pkg::REG_NORMAL_SIL:   prdata_o = {16'd0, cfg_q.normal_silence};
      ste_pkg::REG_SHORT_SIL:    prdata_o = {16'd0, cfg_q.short_turn_silence};
      ste_pkg::REG_LONG_SIL:     prdata_o = {16'd0, cfg_q.long_turn_silence};
      ste_pkg::REG_SILENCE_CAP:  prdata_o = {16'd0, cfg_q.silence_cap};
      ste_pkg::REG_MIN_RECORD:   prdata_o = {16'd0, cfg_q.min_record};
      ste_pkg::REG_MAX_RECORD:   prdata_o = {16'd0, cfg_q.max_record};
      default:                   prdata_o = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout       <= 15'd8000;
      cfg_q.start_frames       <= 8'd3;
      cfg_q.normal_silence     <= 16'd700;
      cfg_q.short_turn_silence <= 16'd1200;
      cfg_q.long_turn_silence  <= 16'd500;
      cfg_q.silence_cap        <= 16'd2000;
      cfg_q.min_record         <= 16'd300;
      cfg_q.max_record         <= 16'd15000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
